// File: src/pmfp_pkg.sv
// Shared types and constants for the physical memory and frame pool block.
// Used by pmfp_pool, phys_mem_frame_pool and the testbench; depends on nothing else.
package pmfp_pkg;

  // Default sizes of the byte memory and of one page frame.
  localparam int MEM_BYTES_DEF  = 4096;
  localparam int PAGE_BYTES_DEF = 256;
  localparam int FRAMES_DEF     = MEM_BYTES_DEF / PAGE_BYTES_DEF;

  // Command codes carried by a request.
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TAKE   = 2'd2,
    CMD_RETURN = 2'd3
  } cmd_t;

  // Operation handed to the frame pool in the cycle a request is accepted.
  typedef struct packed {
    logic       take;
    logic       give;
    logic [7:0] frame;
  } pool_req_t;

  // Pool status: busy while formatting, ok for the current operation
  // (same cycle), frame popped by the last take (registered).
  typedef struct packed {
    logic       busy;
    logic       ok;
    logic [7:0] frame;
  } pool_rsp_t;

endpackage

// File: src/pmfp_pool.sv
// Free frame pool: a LIFO stack of frame numbers held in a synchronous RAM.
// Depends on pmfp_pkg for the request and response structs.
module pmfp_pool import pmfp_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pool_req_t req,
  output pool_rsp_t rsp
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [FW-1:0] stack_mem [FRAMES];

  logic          init_r, init_nxt;
  logic [FW-1:0] init_idx_r, init_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [FW-1:0] pop_q_r;
  logic [CW-1:0] count_m1;
  logic          take_ok, give_ok;

  // Legality of the current operation against the fill level.
  always_comb begin
    count_m1 = count_r - CW'(1);
    take_ok  = req.take && (count_r != '0);
    give_ok  = req.give && (32'(req.frame) < FRAMES) && (32'(count_r) < FRAMES);
  end

  // Formatting sweep and fill level.
  always_comb begin
    init_nxt     = init_r;
    init_idx_nxt = init_idx_r;
    count_nxt    = count_r;
    if (init_r) begin
      init_idx_nxt = init_idx_r + FW'(1);
      if (32'(init_idx_r) == FRAMES - 1) begin
        init_nxt = 1'b0;
      end
    end else if (take_ok) begin
      count_nxt = count_m1;
    end else if (give_ok) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r     <= 1'b1;
      init_idx_r <= '0;
      count_r    <= CW'(FRAMES);
    end else begin
      init_r     <= init_nxt;
      init_idx_r <= init_idx_nxt;
      count_r    <= count_nxt;
    end
  end

  // Stack RAM: the sweep lays out frames so that frame 0 ends on top,
  // a return pushes at the fill level, a take reads just below it.
  always_ff @(posedge clk) begin
    if (init_r) begin
      stack_mem[init_idx_r] <= FW'(FRAMES - 1) - init_idx_r;
    end else if (give_ok) begin
      stack_mem[count_r[FW-1:0]] <= FW'(req.frame);
    end
    if (take_ok) begin
      pop_q_r <= stack_mem[count_m1[FW-1:0]];
    end
  end

  assign rsp.busy  = init_r;
  assign rsp.ok    = take_ok || give_ok;
  assign rsp.frame = 8'(pop_q_r);

endmodule

// File: src/phys_mem_frame_pool.sv
// Byte-wide physical memory with a LIFO pool of free page frames.
// Each result is registered in the RAM stage, then in the output register.
// Throughput: one request per cycle unless out_stall holds the output; the
// byte RAM and the stack RAM each see one access per request, so there is no
// conflict between requests. Reset: a sweep clears the byte RAM and formats
// the frame stack; no request is accepted until it ends.
module phys_mem_frame_pool import pmfp_pkg::*; #(
  parameter int MEM_BYTES  = MEM_BYTES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_byte_addr,
  input  logic [7:0]  in_write_byte,
  input  logic [7:0]  in_frame_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [7:0]  out_read_byte,
  output logic [7:0]  out_frame_out
);

  localparam int FRAMES = MEM_BYTES / PAGE_BYTES;
  localparam int AW     = $clog2(MEM_BYTES);

  logic [7:0] mem [MEM_BYTES];

  logic          clear_r, clear_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [7:0]    mem_q_r;

  logic          s1_valid_r, s1_valid_nxt;
  cmd_t          s1_cmd_r;
  logic          s1_err_r;

  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r;
  logic [7:0]    out_read_byte_r, out_frame_out_r;

  cmd_t          cmd;
  logic          acc, addr_ok, err, s1_adv, s1_move;
  pool_req_t     pool_req;
  pool_rsp_t     pool_rsp;

  pmfp_pool #(.FRAMES(FRAMES)) u_pool (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pool_req),
    .rsp   (pool_rsp)
  );

  // Handshake and request decode.
  always_comb begin
    cmd      = cmd_t'(in_cmd);
    s1_adv   = !out_valid_r || !out_stall;
    s1_move  = s1_valid_r && s1_adv;
    in_stall = clear_r || pool_rsp.busy || (s1_valid_r && !s1_adv);
    acc      = in_valid && !in_stall;
    addr_ok  = 32'(in_byte_addr) < MEM_BYTES;
    pool_req.take  = acc && (cmd == CMD_TAKE);
    pool_req.give  = acc && (cmd == CMD_RETURN);
    pool_req.frame = in_frame_in;
    case (cmd)
      CMD_READ, CMD_WRITE: err = !addr_ok;
      default:             err = !pool_rsp.ok;
    endcase
  end

  // Clearing sweep over the byte RAM after reset.
  always_comb begin
    clear_nxt   = clear_r;
    clr_idx_nxt = clr_idx_r;
    if (clear_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (32'(clr_idx_r) == MEM_BYTES - 1) begin
        clear_nxt = 1'b0;
      end
    end
  end

  // Byte RAM: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (clear_r) begin
      mem[clr_idx_r] <= 8'd0;
    end else if (acc && (cmd == CMD_WRITE) && addr_ok) begin
      mem[in_byte_addr[AW-1:0]] <= in_write_byte;
    end
    if (acc && (cmd == CMD_READ)) begin
      mem_q_r <= mem[in_byte_addr[AW-1:0]];
    end
  end

  // Occupancy of the RAM stage and of the output register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r     <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clear_r     <= clear_nxt;
      clr_idx_r   <= clr_idx_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: command and error at acceptance, then the formatted result.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r <= cmd;
      s1_err_r <= err;
    end
    if (s1_move) begin
      out_status_r    <= s1_err_r;
      out_read_byte_r <= ((s1_cmd_r == CMD_READ) && !s1_err_r) ? mem_q_r : 8'd0;
      out_frame_out_r <= ((s1_cmd_r == CMD_TAKE) && !s1_err_r) ? pool_rsp.frame : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_byte = out_read_byte_r;
  assign out_frame_out = out_frame_out_r;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for phys_mem_frame_pool: byte reads and writes, frame takes and returns.
// Depends on pmfp_pkg for command codes and default sizes; predicts results the table omits.
module testbench;
  import pmfp_pkg::*;

  localparam int RAND_ITEMS = 1880;
  localparam int PLAN_LEN   = 23;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic       status;
    logic [7:0] rd;
    logic [7:0] fo;
  } outcome_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  wb;
    logic [7:0]  fr;
    int          reps;
    bit          typed;
    outcome_t    want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [15:0] in_byte_addr;
  logic [7:0]  in_write_byte;
  logic [7:0]  in_frame_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [7:0]  out_read_byte;
  logic [7:0]  out_frame_out;

  // Shadow copy of the memory and the free-frame stack.
  logic [7:0] mem_image [MEM_BYTES_DEF];
  logic [7:0] free_frames [FRAMES_DEF];
  int         free_cnt;
  logic [7:0] held_frames [$];

  outcome_t outcome_q [$];
  int       errors;
  int       sent_count;
  bit       calm;
  bit       hold_req;
  bit       hold_on;
  bit       take_phase;

  // Directed requests: reset contents, address extremes, pool full, empty, bad and duplicate frames.
  plan_row_t plan [PLAN_LEN] = '{
    '{CMD_READ,   16'h0000, 8'hFF, 8'hFF, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_READ,   16'h0FFF, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_READ,   16'h1000, 8'h00, 8'h00, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_READ,   16'hFFFF, 8'hFF, 8'hFF, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_WRITE,  16'h0000, 8'hFF, 8'hFF, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_WRITE,  16'h0FFF, 8'hA5, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_WRITE,  16'h1000, 8'h5A, 8'h00, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_WRITE,  16'hFFFF, 8'h00, 8'hFF, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_READ,   16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'hFF, 8'h00}},
    '{CMD_READ,   16'h0FFF, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'hA5, 8'h00}},
    '{CMD_RETURN, 16'h0000, 8'h00, 8'h03, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'hFFFF, 8'hFF, 8'hFF, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h01}},
    '{CMD_RETURN, 16'h0000, 8'h00, 8'h10, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_RETURN, 16'hFFFF, 8'hFF, 8'hFF, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_RETURN, 16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_RETURN, 16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'h0000, 8'h00, 8'h00, 14, 1'b0, {1'b0, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b1, 8'h00, 8'h00}},
    '{CMD_RETURN, 16'h0000, 8'h00, 8'h0F, 1,  1'b1, {1'b0, 8'h00, 8'h00}},
    '{CMD_TAKE,   16'h0000, 8'h00, 8'h00, 1,  1'b1, {1'b0, 8'h00, 8'h0F}}
  };

  phys_mem_frame_pool uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_byte_addr  (in_byte_addr),
    .in_write_byte (in_write_byte),
    .in_frame_in   (in_frame_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_byte (out_read_byte),
    .out_frame_out (out_frame_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic flag_error(input string what, input int got, input int want);
    if (errors < 40) begin
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  // Shadow state as it stands after reset: memory clear, frame 0 on top of a full stack.
  task automatic clear_shadow();
    for (int i = 0; i < MEM_BYTES_DEF; i++) begin
      mem_image[i] = 8'h00;
    end
    for (int i = 0; i < FRAMES_DEF; i++) begin
      free_frames[i] = 8'(FRAMES_DEF - 1 - i);
    end
    free_cnt = FRAMES_DEF;
  endtask

  // Applies one request to the shadow state and returns what the block should answer.
  function automatic outcome_t predict_outcome(input cmd_t c, input logic [15:0] a,
                                               input logic [7:0] d, input logic [7:0] f);
    outcome_t r;
    r = '0;
    case (c)
      CMD_READ: begin
        if (a < MEM_BYTES_DEF) r.rd = mem_image[a];
        else r.status = 1'b1;
      end
      CMD_WRITE: begin
        if (a < MEM_BYTES_DEF) mem_image[a] = d;
        else r.status = 1'b1;
      end
      CMD_TAKE: begin
        if (free_cnt > 0) begin
          free_cnt--;
          r.fo = free_frames[free_cnt];
          held_frames.push_back(r.fo);
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        if (f < FRAMES_DEF && free_cnt < FRAMES_DEF) begin
          free_frames[free_cnt] = f;
          free_cnt++;
        end else begin
          r.status = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Offers one request, waits for it to be taken, and records the expected answer.
  task automatic issue_request(input cmd_t c, input logic [15:0] a, input logic [7:0] d,
                               input logic [7:0] f, input bit typed, input outcome_t want);
    outcome_t guess;
    int gap;
    if (!calm && !hold_on && (sent_count / 128) % 3 != 2 && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_byte_addr  <= a;
    in_write_byte <= d;
    in_frame_in   <= f;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = predict_outcome(c, a, d, f);
    outcome_q.push_back(typed ? want : guess);
    sent_count++;
    @(negedge clk);
  endtask

  // Random request: mostly addresses near the ends of memory so reads find written data,
  // pool operations leaning toward takes or returns so the stack swings between empty and full.
  task automatic pick_request(output cmd_t c, output logic [15:0] a, output logic [7:0] d,
                              output logic [7:0] f);
    int sel;
    int idx;
    sel = $urandom_range(0, 99);
    if (sel < 40) a = 16'($urandom_range(0, 63));
    else if (sel < 60) a = 16'(MEM_BYTES_DEF - 64 + $urandom_range(0, 63));
    else if (sel < 90) a = 16'($urandom_range(0, MEM_BYTES_DEF - 1));
    else a = 16'($urandom_range(0, 16'hFFFF));
    d = 8'($urandom_range(0, 255));
    f = 8'($urandom_range(0, 255));

    if (free_cnt == 0) take_phase = 1'b0;
    else if (free_cnt == FRAMES_DEF) take_phase = 1'b1;
    else if ($urandom_range(0, 39) == 0) take_phase = ~take_phase;

    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      c = CMD_READ;
    end else if (sel < 55) begin
      c = CMD_WRITE;
    end else if (take_phase ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0)) begin
      c = CMD_TAKE;
    end else begin
      c = CMD_RETURN;
      sel = $urandom_range(0, 99);
      if (sel < 70 && held_frames.size() > 0) begin
        idx = $urandom_range(0, held_frames.size() - 1);
        f = held_frames[idx];
        held_frames.delete(idx);
      end else if (sel < 90) begin
        f = 8'($urandom_range(0, FRAMES_DEF - 1));
      end
    end
  endtask

  // Result side: random stall bursts, quiet stretches, and one long hold-off on request.
  initial begin
    int stall_left;
    int rx_cyc;
    bit nxt;
    out_stall  = 1'b0;
    stall_left = 0;
    rx_cyc     = 0;
    hold_on    = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_on    = 1'b1;
        stall_left = LONG_HOLD - 1;
        nxt        = 1'b1;
      end else if (!calm && (rx_cyc / 256) % 3 != 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        nxt        = 1'b1;
      end else begin
        nxt = 1'b0;
      end
      if (stall_left == 0) hold_on = 1'b0;
      out_stall <= nxt;
    end
  end

  // Every accepted result is compared against the oldest expectation.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (outcome_q.size() == 0) begin
        flag_error("result with no request pending", 1, 0);
      end else begin
        want = outcome_q.pop_front();
        if (out_status !== want.status) flag_error("status", out_status, want.status);
        if (out_read_byte !== want.rd) flag_error("read_byte", out_read_byte, want.rd);
        if (out_frame_out !== want.fo) flag_error("frame_out", out_frame_out, want.fo);
      end
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin
    cmd_t        c;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  f;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_READ;
    in_byte_addr  = '0;
    in_write_byte = '0;
    in_frame_in   = '0;
    errors        = 0;
    sent_count    = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    take_phase    = 1'b1;
    clear_shadow();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        issue_request(plan[i].cmd, plan[i].addr, plan[i].wb, plan[i].fr,
                      plan[i].typed, plan[i].want);
      end
    end

    // The directed part leaves the pool empty with every frame handed out.
    held_frames.delete();
    for (int i = 0; i < FRAMES_DEF; i++) begin
      held_frames.push_back(8'(i));
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 400) hold_req = 1'b1;
      if (i == RAND_ITEMS - 150) calm = 1'b1;
      pick_request(c, a, d, f);
      issue_request(c, a, d, f, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
